// File: sv/cfs_pkg.sv
// Shared constants, types and helpers for the circular FIFO with search.
// No dependencies; imported by every module of the block.
package cfs_pkg;

    localparam int DEPTH     = 16;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OP_W      = 3;
    localparam int WORD_W    = 32;
    localparam int ST_W      = 2;
    localparam int POS_W     = 4;
    localparam int FILL_W    = 5;
    localparam int DATA_BITS = WORD_W + POS_W + FILL_W;
    localparam int M_DATA_W  = ((DATA_BITS + 7) / 8) * 8;
    localparam int PAD_W     = M_DATA_W - DATA_BITS;

    localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
    localparam logic [OP_W-1:0] OP_POP      = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK_OLD = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK_NEW = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    typedef logic [PTR_W-1:0]         ptr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_TAIL,
        RD_SCAN
    } rd_sel_t;

    typedef struct packed {
        logic            in_valid;
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            hit;
        logic            last;
        logic            out_free;
    } flags_t;

    typedef struct packed {
        logic            in_ready;
        logic            push_en;
        logic            pop_en;
        logic            rd_en;
        rd_sel_t         rd_sel;
        logic            scan_start;
        logic            scan_adv;
        logic            res_load;
        logic [ST_W-1:0] res_status;
        logic            res_word_sel;
        logic            res_pos_sel;
        logic            out_load;
    } ctrl_t;

    function automatic ptr_t next_ptr(input ptr_t p);
        ptr_t r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

endpackage

// File: sv/cfs_store.sv
// Slot memory of the circular FIFO: one write port, one registered read port.
// Depends on cfs_pkg for depth and word types.
module cfs_store
    import cfs_pkg::*;
(
    input  logic  aclk,
    input  logic  we,
    input  ptr_t  waddr,
    input  word_t wdata,
    input  logic  re,
    input  ptr_t  raddr,
    output word_t rd_data
);

    word_t slot_mem [DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            slot_mem[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= slot_mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/cfs_seq.sv
// Sequencer of the circular FIFO: accepts a request, steps reads and the scan,
// and hands the result to the output register. Depends on cfs_pkg.
module cfs_seq
    import cfs_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (flags.in_valid) begin
                    case (flags.op)
                        OP_POP, OP_PEEK_OLD, OP_PEEK_NEW: begin
                            state_next = flags.empty ? S_DONE : S_READ;
                        end
                        OP_SEARCH: begin
                            state_next = flags.empty ? S_DONE : S_SCAN;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                state_next = S_DONE;
            end
            S_SCAN: begin
                if (flags.hit || flags.last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (flags.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        ctrl.rd_sel = RD_HEAD;
        ctrl.res_status = ST_OK;
        case (state_reg)
            S_IDLE: begin
                ctrl.in_ready = 1'b1;
                if (flags.in_valid) begin
                    ctrl.res_load = 1'b1;
                    case (flags.op)
                        OP_PUSH: begin
                            ctrl.push_en    = !flags.full;
                            ctrl.res_status = flags.full ? ST_FULL : ST_OK;
                        end
                        OP_POP: begin
                            ctrl.pop_en     = !flags.empty;
                            ctrl.rd_en      = !flags.empty;
                            ctrl.res_status = flags.empty ? ST_EMPTY : ST_OK;
                        end
                        OP_PEEK_OLD: begin
                            ctrl.rd_en      = !flags.empty;
                            ctrl.res_status = flags.empty ? ST_EMPTY : ST_OK;
                        end
                        OP_PEEK_NEW: begin
                            ctrl.rd_en      = !flags.empty;
                            ctrl.rd_sel     = RD_TAIL;
                            ctrl.res_status = flags.empty ? ST_EMPTY : ST_OK;
                        end
                        OP_SEARCH: begin
                            ctrl.rd_en      = !flags.empty;
                            ctrl.scan_start = !flags.empty;
                            ctrl.res_status = flags.empty ? ST_EMPTY : ST_OK;
                        end
                        default: begin
                            ctrl.res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                ctrl.res_load     = 1'b1;
                ctrl.res_word_sel = 1'b1;
            end
            S_SCAN: begin
                if (flags.hit) begin
                    ctrl.res_load    = 1'b1;
                    ctrl.res_pos_sel = 1'b1;
                end else if (flags.last) begin
                    ctrl.res_load   = 1'b1;
                    ctrl.res_status = ST_NOTFOUND;
                end else begin
                    ctrl.scan_adv = 1'b1;
                    ctrl.rd_en    = 1'b1;
                    ctrl.rd_sel   = RD_SCAN;
                end
            end
            S_DONE: begin
                ctrl.out_load = flags.out_free;
            end
            default: begin
                ctrl.in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/circular_fifo_with_search_core.sv
// Top level of the circular FIFO with search: pointers, occupancy, compare
// unit and output register. Depends on cfs_pkg, cfs_store and cfs_seq.
//
// A circular FIFO of DEPTH signed 32-bit words behind one request stream: each
// request word pushes, pops, peeks at the oldest or newest entry, or searches
// for a value, and gives exactly one result word with status, data, match
// position and fill count. One request is in work at a time. Push, empty or
// full refusals and unused opcodes go from acceptance straight to the done
// state; pop and peeks pass through a read state first, since the slot memory
// has one registered read port; a search passes through the scan state, which
// reads and compares one entry per cycle, at most DEPTH entries, through that
// same port and a single comparator. The result sits in an output register,
// so the block takes its next request while that result waits.
module circular_fifo_with_search_core
    import cfs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [WORD_W-1:0]    s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]      s_tuser,   // [2:0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [31:0] word_out, [35:32] position,
                                            // [40:36] fill_count, rest zero
    output logic [ST_W-1:0]      m_tuser    // [1:0] status
);

    flags_t flags;
    ctrl_t  ctrl;

    ptr_t            head_reg, head_next;
    ptr_t            tail_reg, tail_next;
    cnt_t            occ_reg, occ_next;
    word_t           val_reg, val_next;
    ptr_t            scan_addr_reg, scan_addr_next;
    ptr_t            idx_reg, idx_next;
    logic [ST_W-1:0] res_status_reg, res_status_next;
    word_t           res_word_reg, res_word_next;
    ptr_t            res_pos_reg, res_pos_next;
    logic            m_valid_reg, m_valid_next;
    logic [ST_W-1:0] m_status_reg, m_status_next;
    word_t           m_word_reg, m_word_next;
    logic [POS_W-1:0]  m_pos_reg, m_pos_next;
    logic [FILL_W-1:0] m_fill_reg, m_fill_next;

    ptr_t  rd_addr;
    word_t rd_data;

    cfs_store u_store (
        .aclk    (aclk),
        .we      (ctrl.push_en),
        .waddr   (next_ptr(tail_reg)),
        .wdata   (word_t'(s_tdata)),
        .re      (ctrl.rd_en),
        .raddr   (rd_addr),
        .rd_data (rd_data)
    );

    cfs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    always_comb begin
        flags.in_valid = s_tvalid;
        flags.op       = s_tuser;
        flags.empty    = (occ_reg == '0);
        flags.full     = (occ_reg == CNT_W'(DEPTH));
        flags.hit      = (rd_data == val_reg);
        flags.last     = ((CNT_W'(idx_reg) + CNT_W'(1)) == occ_reg);
        flags.out_free = !m_valid_reg || m_tready;
    end

    always_comb begin
        case (ctrl.rd_sel)
            RD_HEAD: rd_addr = head_reg;
            RD_TAIL: rd_addr = tail_reg;
            RD_SCAN: rd_addr = scan_addr_reg;
            default: rd_addr = head_reg;
        endcase
    end

    always_comb begin
        head_next       = ctrl.pop_en ? next_ptr(head_reg) : head_reg;
        tail_next       = ctrl.push_en ? next_ptr(tail_reg) : tail_reg;
        occ_next        = occ_reg;
        if (ctrl.push_en) begin
            occ_next = occ_reg + CNT_W'(1);
        end else if (ctrl.pop_en) begin
            occ_next = occ_reg - CNT_W'(1);
        end
        val_next        = (ctrl.in_ready && s_tvalid) ? word_t'(s_tdata) : val_reg;
        scan_addr_next  = scan_addr_reg;
        idx_next        = idx_reg;
        if (ctrl.scan_start) begin
            scan_addr_next = next_ptr(head_reg);
            idx_next       = '0;
        end else if (ctrl.scan_adv) begin
            scan_addr_next = next_ptr(scan_addr_reg);
            idx_next       = idx_reg + PTR_W'(1);
        end
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;
        res_pos_next    = res_pos_reg;
        if (ctrl.res_load) begin
            res_status_next = ctrl.res_status;
            res_word_next   = ctrl.res_word_sel ? rd_data : '0;
            res_pos_next    = ctrl.res_pos_sel ? idx_reg : '0;
        end
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_word_next   = m_word_reg;
        m_pos_next    = m_pos_reg;
        m_fill_next   = m_fill_reg;
        if (ctrl.out_load) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_word_next   = res_word_reg;
            m_pos_next    = POS_W'(res_pos_reg);
            m_fill_next   = FILL_W'(occ_reg);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= PTR_W'(DEPTH - 1);
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg        <= val_next;
        scan_addr_reg  <= scan_addr_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_word_reg   <= res_word_next;
        res_pos_reg    <= res_pos_next;
        m_status_reg   <= m_status_next;
        m_word_reg     <= m_word_next;
        m_pos_reg      <= m_pos_next;
        m_fill_reg     <= m_fill_next;
    end

    assign s_tready = ctrl.in_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_fill_reg, m_pos_reg, m_word_reg};

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while one is in work");

    a_occ_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (occ_reg != $past(occ_reg)) |-> $past(s_tvalid && s_tready))
        else $error("occupancy changed without an accepted word");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.scan_adv |-> ((CNT_W'(idx_reg) + CNT_W'(1)) < occ_reg))
        else $error("scan advanced past newest entry");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten while held");
`endif

endmodule
